FILE: design/assert_macros.svh
// Assertion shorthands shared by the converter RTL.
// Every macro expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent this cycle implies consequent next cycle; quiet while in reset.
`define ASSERT_IMPLY_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// Same check with reset left live, for checking reset behavior itself.
`define ASSERT_RESET_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset behavior check failed");

`endif

FILE: design/cddn_pkg.sv
// Shared types, constants and small tables for the civil date / day number converter.
// Used by cddn_ctrl, cddn_d2n, cddn_n2d and the top level; depends on nothing.
package cddn_pkg;

  // Pipeline depth: datapath stages plus the output register.
  localparam int NS         = 11;
  localparam int D2N_STAGES = 5;
  localparam int DLY_N      = NS - 1 - D2N_STAGES;

  typedef enum logic {
    CMD_TO_DAYS = 1'b0,
    CMD_TO_DATE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [NS-1:0] en;
    logic [NS-1:0] vld;
    logic [NS-1:0] cmd;
  } pipe_ctl_t;

  typedef struct packed {
    logic signed [23:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic               oor;
  } date_t;

  // Calendar constants.
  localparam logic [17:0]        DAYS_ERA     = 18'd146097;
  localparam logic signed [18:0] DAYS_ERA_S   = 19'sd146097;
  localparam logic [8:0]         YEARS_ERA    = 9'd400;
  localparam logic signed [9:0]  YEARS_ERA_S  = 10'sd400;
  localparam logic [8:0]         DAYS_YEAR    = 9'd365;
  localparam logic signed [20:0] DAYS_EPOCH_S = 21'sd719468;
  localparam longint unsigned    DAYS_EPOCH   = 64'd719468;

  localparam logic signed [33:0] YEAR_MAX = 34'sd8388607;
  localparam logic signed [33:0] YEAR_MIN = -34'sd8388608;

  // Date to days: bias the 25-bit year so the era divide sees a non-negative value.
  localparam longint unsigned C_Y_L   = ((64'd1 << 23) + 64'd400) / 64'd400;
  localparam logic [16:0]     C_Y     = 17'(C_Y_L);
  localparam logic [24:0]     OFF_Y   = 25'(C_Y_L * 64'd400);
  localparam int              K_400   = 34;
  localparam logic [25:0]     M_400   = 26'(((64'd1 << K_400) + 64'd399) / 64'd400);

  // Days to date: bias the day count by a whole number of eras.
  localparam longint unsigned C_ERA_L = ((64'd1 << 39) + 64'd146096) / 64'd146097;
  localparam logic [24:0]     C_ERA   = 25'(C_ERA_L);
  localparam logic [40:0]     K_N2D   = 41'(DAYS_EPOCH + C_ERA_L * 64'd146097);
  // Floor reciprocal: the estimate is at most one low and gets one correction step.
  localparam logic [23:0]     M_ERA   = 24'((64'd1 << 41) / 64'd146097);

  // Exact ceiling reciprocals for the narrow divides inside an era.
  localparam int          K_1460  = 29;
  localparam logic [18:0] M_1460  = 19'(((64'd1 << K_1460) + 64'd1459) / 64'd1460);
  localparam int          K_36524 = 34;
  localparam logic [18:0] M_36524 = 19'(((64'd1 << K_36524) + 64'd36523) / 64'd36524);
  localparam int          K_365   = 27;
  localparam logic [18:0] M_365   = 19'(((64'd1 << K_365) + 64'd364) / 64'd365);
  localparam int          K_153   = 19;
  localparam longint unsigned M_153_L = ((64'd1 << K_153) + 64'd152) / 64'd153;
  // (5*doy + 2) / 153 folded into one multiply and a constant.
  localparam logic [14:0] MP_MUL  = 15'(M_153_L * 64'd5);
  localparam logic [23:0] MP_ADD  = 24'(M_153_L * 64'd2);

  // Days before the month, counting from March: (153*mm + 2) / 5.
  function automatic logic [8:0] month_off(input logic [3:0] mm);
    logic [8:0] off;
    case (mm)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      4'd12:   off = 9'd367;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  // Century index within an era (yoe / 100).
  function automatic logic [1:0] cent_of(input logic [8:0] yoe);
    logic [1:0] c;
    if (yoe >= 9'd300) begin
      c = 2'd3;
    end else if (yoe >= 9'd200) begin
      c = 2'd2;
    end else if (yoe >= 9'd100) begin
      c = 2'd1;
    end else begin
      c = 2'd0;
    end
    return c;
  endfunction

endpackage

FILE: design/civil_date_day_number_converter_unit.sv
// Proleptic Gregorian converter between civil dates and signed day counts
// relative to 1970-01-01. Top level; depends on cddn_pkg, cddn_ctrl, cddn_d2n,
// cddn_n2d and assert_macros.svh.
//
// Input channel (in_valid / in_stall): in_command 0 takes in_year, in_month,
// in_day and returns out_day_count; in_command 1 takes in_day_count and returns
// out_year, out_month, out_day and out_of_range (year clamped to 24 bits).
// Fields not used by the command read as zero. Each item gives one result item.
//
// There are 11 register stages, counting the output register. The first loads
// at the accepting edge. Throughput is one item per cycle while out_stall is
// low. The depth is set by the day-to-date path: a split 41-bit era divide with
// a one-step correction, then the in-era divides, each a registered reciprocal
// multiply.
//
// Synchronous active-low reset empties the pipeline. When out_stall is high the
// output item holds; stages behind it keep filling until every stage is full,
// and only then in_stall rises. No item is dropped or repeated.
`include "assert_macros.svh"

module civil_date_day_number_converter_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic signed [23:0] in_year,
  input  logic [3:0]         in_month,
  input  logic [4:0]         in_day,
  input  logic signed [39:0] in_day_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [39:0] out_day_count,
  output logic signed [23:0] out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output logic               out_of_range
);

  cddn_pkg::pipe_ctl_t ctl;
  cddn_pkg::date_t     date;
  logic signed [39:0]  dc;

  logic signed [39:0]  dc_r;
  logic signed [23:0]  year_r;
  logic [3:0]          month_r;
  logic [4:0]          day_r;
  logic                oor_r;

  cddn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_stall  (out_stall),
    .ctl        (ctl)
  );

  cddn_d2n u_d2n (
    .clk       (clk),
    .ctl       (ctl),
    .in_year   (in_year),
    .in_month  (in_month),
    .in_day    (in_day),
    .day_count (dc)
  );

  cddn_n2d u_n2d (
    .clk          (clk),
    .ctl          (ctl),
    .in_day_count (in_day_count),
    .date         (date)
  );

  // Output register: pick the result for the item's command, zero the rest.
  always_ff @(posedge clk) begin
    if (ctl.en[cddn_pkg::NS-1]) begin
      if (ctl.cmd[cddn_pkg::NS-2] == cddn_pkg::CMD_TO_DATE) begin
        dc_r    <= '0;
        year_r  <= date.year;
        month_r <= date.month;
        day_r   <= date.day;
        oor_r   <= date.oor;
      end else begin
        dc_r    <= dc;
        year_r  <= '0;
        month_r <= '0;
        day_r   <= '0;
        oor_r   <= 1'b0;
      end
    end
  end

  assign out_valid     = ctl.vld[cddn_pkg::NS-1];
  assign out_day_count = dc_r;
  assign out_year      = year_r;
  assign out_month     = month_r;
  assign out_day       = day_r;
  assign out_of_range  = oor_r;

  `ASSERT_IMPLY_NEXT(a_accept_enters, in_valid && !in_stall, ctl.vld[0])
  `ASSERT_IMPLY_NEXT(a_no_repeat, out_valid && !out_stall && !ctl.vld[cddn_pkg::NS-2], !out_valid)
  `ASSERT_RESET_NEXT(a_reset_empties, !rst_n, !out_valid && !ctl.vld[0])

endmodule

FILE: design/cddn_ctrl.sv
// Pipeline control for the converter: valid and command bits per stage, stage enables.
// Depends on cddn_pkg.
module cddn_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_command,
  output logic                  in_stall,
  input  logic                  out_stall,
  output cddn_pkg::pipe_ctl_t   ctl
);

  logic [cddn_pkg::NS-1:0] vld_r;
  logic [cddn_pkg::NS-1:0] vld_nxt;
  logic [cddn_pkg::NS-1:0] cmd_r;
  logic [cddn_pkg::NS-1:0] cmd_nxt;
  logic [cddn_pkg::NS-1:0] en;

  // A stage loads when it is empty or its successor loads, so bubbles close up.
  always_comb begin
    en[cddn_pkg::NS-1] = !vld_r[cddn_pkg::NS-1] || !out_stall;
    for (int i = cddn_pkg::NS-2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    cmd_nxt = cmd_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
      cmd_nxt[0] = in_command;
    end
    for (int i = 1; i < cddn_pkg::NS; i++) begin
      if (en[i]) begin
        vld_nxt[i] = vld_r[i-1];
        cmd_nxt[i] = cmd_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  assign in_stall = !en[0];
  assign ctl.en   = en;
  assign ctl.vld  = vld_r;
  assign ctl.cmd  = cmd_r;

endmodule

FILE: design/cddn_d2n.sv
// Civil date to day number datapath: five compute stages, then a delay line to
// line up with the day-number-to-date path. Depends on cddn_pkg.
module cddn_d2n (
  input  logic                clk,
  input  cddn_pkg::pipe_ctl_t ctl,
  input  logic signed [23:0]  in_year,
  input  logic [3:0]          in_month,
  input  logic [4:0]          in_day,
  output logic signed [39:0]  day_count
);

  // Stage 0: shift Jan/Feb into the previous year, bias year, day of year.
  logic signed [24:0] y_adj;
  logic [3:0]         mm;
  logic [24:0]        s0_n_nxt;
  logic signed [9:0]  s0_doy_nxt;
  logic [24:0]        s0_n_r;
  logic signed [9:0]  s0_doy_r;

  // Stage 1: era quotient.
  logic [50:0]        q_prod;
  logic [16:0]        s1_q_r;
  logic [24:0]        s1_n_r;
  logic signed [9:0]  s1_doy_r;

  // Stage 2: year of era and signed era.
  logic [8:0]         s2_yoe_nxt;
  logic signed [16:0] s2_era_nxt;
  logic [8:0]         s2_yoe_r;
  logic signed [16:0] s2_era_r;
  logic signed [9:0]  s2_doy_r;

  // Stage 3: day of era and era days.
  logic signed [18:0] s3_doe_nxt;
  logic signed [35:0] s3_ed_nxt;
  logic signed [18:0] s3_doe_r;
  logic signed [35:0] s3_ed_r;

  // Stage 4: final sum.
  logic signed [40:0] s4_sum;
  logic signed [39:0] s4_dc_r;

  logic signed [39:0] dly_r [cddn_pkg::DLY_N];

  always_comb begin
    y_adj      = in_year - ((in_month <= 4'd2) ? 25'sd1 : 25'sd0);
    s0_n_nxt   = 25'(y_adj) + cddn_pkg::OFF_Y;
    mm         = (in_month > 4'd2) ? in_month - 4'd3 : in_month + 4'd9;
    s0_doy_nxt = 10'(cddn_pkg::month_off(mm)) + 10'(in_day) - 10'd1;
  end

  assign q_prod = s0_n_r * cddn_pkg::M_400;

  always_comb begin
    s2_yoe_nxt = 9'(26'(s1_n_r) - 26'(s1_q_r) * 26'(cddn_pkg::YEARS_ERA));
    s2_era_nxt = s1_q_r - cddn_pkg::C_Y;
  end

  always_comb begin
    s3_doe_nxt = 19'(s2_yoe_r) * 19'(cddn_pkg::DAYS_YEAR) + 19'(s2_yoe_r >> 2)
               - 19'(cddn_pkg::cent_of(s2_yoe_r)) + 19'(s2_doy_r);
    s3_ed_nxt  = s2_era_r * cddn_pkg::DAYS_ERA_S;
  end

  assign s4_sum = 41'(s3_ed_r) + 41'(s3_doe_r) - 41'(cddn_pkg::DAYS_EPOCH_S);

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s0_n_r   <= s0_n_nxt;
      s0_doy_r <= s0_doy_nxt;
    end
    if (ctl.en[1]) begin
      s1_q_r   <= q_prod[50:cddn_pkg::K_400];
      s1_n_r   <= s0_n_r;
      s1_doy_r <= s0_doy_r;
    end
    if (ctl.en[2]) begin
      s2_yoe_r <= s2_yoe_nxt;
      s2_era_r <= s2_era_nxt;
      s2_doy_r <= s1_doy_r;
    end
    if (ctl.en[3]) begin
      s3_doe_r <= s3_doe_nxt;
      s3_ed_r  <= s3_ed_nxt;
    end
    if (ctl.en[4]) begin
      s4_dc_r <= s4_sum[39:0];
    end
  end

  // Delay line: hold each item until the other path catches up.
  always_ff @(posedge clk) begin
    if (ctl.en[cddn_pkg::D2N_STAGES]) begin
      dly_r[0] <= s4_dc_r;
    end
    for (int i = 1; i < cddn_pkg::DLY_N; i++) begin
      if (ctl.en[cddn_pkg::D2N_STAGES + i]) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  assign day_count = dly_r[cddn_pkg::DLY_N-1];

endmodule

FILE: design/cddn_n2d.sv
// Day number to civil date datapath: ten register stages, last one feeds the
// top-level output register through a clamp. Depends on cddn_pkg.
module cddn_n2d (
  input  logic                clk,
  input  cddn_pkg::pipe_ctl_t ctl,
  input  logic signed [39:0]  in_day_count,
  output cddn_pkg::date_t     date
);

  logic [40:0]        s0_n_nxt;
  logic [40:0]        s0_n_r;

  logic [43:0]        s1_ph_nxt;
  logic [44:0]        s1_pl_nxt;
  logic [43:0]        s1_ph_r;
  logic [44:0]        s1_pl_r;
  logic [40:0]        s1_n_r;

  logic [65:0]        s2_sum;
  logic [23:0]        s2_qe_r;
  logic [40:0]        s2_n_r;

  logic [41:0]        s3_p_nxt;
  logic [41:0]        s3_p_r;
  logic [23:0]        s3_qe_r;
  logic [40:0]        s3_n_r;

  logic [41:0]        s4_diff;
  logic [18:0]        s4_rem;
  logic [23:0]        s4_q_nxt;
  logic [17:0]        s4_doe_nxt;
  logic [23:0]        s4_q_r;
  logic [17:0]        s4_doe_r;

  logic [36:0]        s5_pa;
  logic [36:0]        s5_pb;
  logic [23:0]        s5_q_r;
  logic [17:0]        s5_doe_r;
  logic [7:0]         s5_a_r;
  logic [2:0]         s5_b_r;
  logic               s5_c_r;

  logic [17:0]        s6_t_nxt;
  logic [23:0]        s6_q_r;
  logic [17:0]        s6_doe_r;
  logic [17:0]        s6_t_r;

  logic [36:0]        s7_py;
  logic [23:0]        s7_q_r;
  logic [17:0]        s7_doe_r;
  logic [8:0]         s7_yoe_r;

  logic [17:0]        s8_yd;
  logic [8:0]         s8_doy_nxt;
  logic signed [24:0] s8_era;
  logic signed [33:0] s8_e400;
  logic signed [33:0] s8_yb_nxt;
  logic [8:0]         s8_doy_r;
  logic signed [33:0] s8_yb_r;

  logic [23:0]        s9_pm;
  logic [8:0]         s9_doy_r;
  logic signed [33:0] s9_yb_r;
  logic [3:0]         s9_mp_r;

  logic [3:0]         mo;
  logic [8:0]         day_full;
  logic signed [33:0] yfull;

  // Bias by whole eras so every divide below sees an unsigned value.
  assign s0_n_nxt = 41'(in_day_count) + cddn_pkg::K_N2D;

  // Era quotient estimate, split into two partial products.
  always_comb begin
    s1_ph_nxt = s0_n_r[40:21] * cddn_pkg::M_ERA;
    s1_pl_nxt = s0_n_r[20:0] * cddn_pkg::M_ERA;
  end

  assign s2_sum   = {s1_ph_r, 21'd0} + 66'(s1_pl_r);
  assign s3_p_nxt = s2_qe_r * cddn_pkg::DAYS_ERA;

  // Correct a low estimate by one.
  always_comb begin
    s4_diff = {1'b0, s3_n_r} - s3_p_r;
    s4_rem  = s4_diff[18:0];
    if (s4_rem >= 19'(cddn_pkg::DAYS_ERA)) begin
      s4_q_nxt   = s3_qe_r + 24'd1;
      s4_doe_nxt = 18'(s4_rem - 19'(cddn_pkg::DAYS_ERA));
    end else begin
      s4_q_nxt   = s3_qe_r;
      s4_doe_nxt = s4_rem[17:0];
    end
  end

  always_comb begin
    s5_pa = s4_doe_r * cddn_pkg::M_1460;
    s5_pb = s4_doe_r * cddn_pkg::M_36524;
  end

  assign s6_t_nxt = s5_doe_r - 18'(s5_a_r) + 18'(s5_b_r) - 18'(s5_c_r);
  assign s7_py    = s6_t_r * cddn_pkg::M_365;

  always_comb begin
    s8_yd      = 18'(s7_yoe_r) * 18'(cddn_pkg::DAYS_YEAR) + 18'(s7_yoe_r >> 2)
               - 18'(cddn_pkg::cent_of(s7_yoe_r));
    s8_doy_nxt = 9'(s7_doe_r - s8_yd);
    s8_era     = 25'(s7_q_r) - cddn_pkg::C_ERA;
    s8_e400    = s8_era * cddn_pkg::YEARS_ERA_S;
    s8_yb_nxt  = s8_e400 + $signed(34'(s7_yoe_r));
  end

  assign s9_pm = s8_doy_r * cddn_pkg::MP_MUL + cddn_pkg::MP_ADD;

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s0_n_r <= s0_n_nxt;
    end
    if (ctl.en[1]) begin
      s1_ph_r <= s1_ph_nxt;
      s1_pl_r <= s1_pl_nxt;
      s1_n_r  <= s0_n_r;
    end
    if (ctl.en[2]) begin
      s2_qe_r <= s2_sum[64:41];
      s2_n_r  <= s1_n_r;
    end
    if (ctl.en[3]) begin
      s3_p_r  <= s3_p_nxt;
      s3_qe_r <= s2_qe_r;
      s3_n_r  <= s2_n_r;
    end
    if (ctl.en[4]) begin
      s4_q_r   <= s4_q_nxt;
      s4_doe_r <= s4_doe_nxt;
    end
    if (ctl.en[5]) begin
      s5_q_r   <= s4_q_r;
      s5_doe_r <= s4_doe_r;
      s5_a_r   <= s5_pa[36:cddn_pkg::K_1460];
      s5_b_r   <= s5_pb[36:cddn_pkg::K_36524];
      s5_c_r   <= (s4_doe_r == 18'(cddn_pkg::DAYS_ERA - 18'd1));
    end
    if (ctl.en[6]) begin
      s6_q_r   <= s5_q_r;
      s6_doe_r <= s5_doe_r;
      s6_t_r   <= s6_t_nxt;
    end
    if (ctl.en[7]) begin
      s7_q_r   <= s6_q_r;
      s7_doe_r <= s6_doe_r;
      s7_yoe_r <= s7_py[35:cddn_pkg::K_365];
    end
    if (ctl.en[8]) begin
      s8_doy_r <= s8_doy_nxt;
      s8_yb_r  <= s8_yb_nxt;
    end
    if (ctl.en[9]) begin
      s9_doy_r <= s8_doy_r;
      s9_yb_r  <= s8_yb_r;
      s9_mp_r  <= s9_pm[22:cddn_pkg::K_153];
    end
  end

  // Month, day and clamped year from the last stage.
  always_comb begin
    mo       = (s9_mp_r < 4'd10) ? s9_mp_r + 4'd3 : s9_mp_r - 4'd9;
    day_full = s9_doy_r - cddn_pkg::month_off(s9_mp_r) + 9'd1;
    yfull    = s9_yb_r + ((mo <= 4'd2) ? 34'sd1 : 34'sd0);
    date.month = mo;
    date.day   = day_full[4:0];
    if (yfull > cddn_pkg::YEAR_MAX) begin
      date.year = cddn_pkg::YEAR_MAX[23:0];
      date.oor  = 1'b1;
    end else if (yfull < cddn_pkg::YEAR_MIN) begin
      date.year = cddn_pkg::YEAR_MIN[23:0];
      date.oor  = 1'b1;
    end else begin
      date.year = yfull[23:0];
      date.oor  = 1'b0;
    end
  end

endmodule
